[src/sssg_pkg.sv]
// ----------------------------------------------------------------------------
// sssg_pkg
// Shared types, constants and the quarter-wave sine table of the shake
// generator.
// ----------------------------------------------------------------------------
package sssg_pkg;

    localparam int POS_W       = 11;
    localparam int AMP_W       = POS_W + 4;
    localparam int PHASE_W     = 32;
    localparam int SINE_ADDR_W = 10;
    localparam int QTR_W       = SINE_ADDR_W - 2;
    localparam int SINE_QTR    = 1 << QTR_W;
    localparam int MAG_W       = 17;
    localparam int PROD_W      = AMP_W + MAG_W;
    localparam int OFF_W       = POS_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [POS_W-1:0] MAX_POS      = POS_W'(2047);
    localparam logic [POS_W-1:0] CENTER_RESET = POS_W'(1024);

    localparam logic [CFG_IDX_W-1:0] CFG_CENTER     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = CFG_IDX_W'(2);

    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] SINE_COEF [0:6] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };

    typedef logic [MAG_W-1:0] mag_rom_t [0:SINE_QTR];

    typedef struct packed {
        logic [POS_W-1:0] center;
        logic [AMP_W-1:0] amp;
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             limited;
        logic             moving;
    } stage_t;

    function automatic mag_rom_t build_sine_rom();
        mag_rom_t    rom;
        logic [63:0] v;
        logic [63:0] v2;
        logic [63:0] t;
        logic [63:0] sub;
        logic [63:0] m;
        for (int u = 0; u <= SINE_QTR; u++)
        begin
            v  = 64'(u) << (30 - QTR_W);
            v2 = (v * v) >> 30;
            t  = SINE_COEF[6];
            for (int k = 5; k >= 0; k--)
            begin
                sub = (v2 * t) >> 30;
                t   = (SINE_COEF[k] > sub) ? (SINE_COEF[k] - sub) : 64'd0;
            end
            t = (v * t) >> 30;
            if (t > Q30_ONE)
            begin
                t = Q30_ONE;
            end
            m = (t + 64'd8192) >> 14;
            if (m > 64'd65536)
            begin
                m = 64'd65536;
            end
            rom[u] = m[MAG_W-1:0];
        end
        return rom;
    endfunction

    localparam mag_rom_t SINE_ROM = build_sine_rom();

endpackage

[src/sssg_phase.sv]
// ----------------------------------------------------------------------------
// sssg_phase
// Amplitude limit, phase accumulator and sine table lookup; registers one
// transaction for the output stage.
// ----------------------------------------------------------------------------
module sssg_phase (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           run,
    input  logic [sssg_pkg::POS_W-1:0]     center,
    input  logic [sssg_pkg::AMP_W-1:0]     amplitude,
    input  logic [sssg_pkg::PHASE_W-1:0]   phase_step,
    output logic                           s1_valid,
    output sssg_pkg::stage_t               s1,
    input  logic                           s1_ready
);
    import sssg_pkg::*;

    logic                   s1_valid_reg;
    stage_t                 s1_reg;
    stage_t                 s1_next;
    logic [PHASE_W-1:0]     phase_acc_reg;
    logic [PHASE_W-1:0]     phase_acc_next;
    logic                   accept;
    logic [POS_W-1:0]       c;
    logic [POS_W-1:0]       hi;
    logic [POS_W-1:0]       lim;
    logic [AMP_W-1:0]       max_amp;
    logic [AMP_W-1:0]       amp;
    logic                   limited;
    logic                   go;
    logic [SINE_ADDR_W-1:0] addr;
    logic [QTR_W-1:0]       r;
    logic [QTR_W:0]         u;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;
    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

    always_comb
    begin
        c       = (center > MAX_POS) ? MAX_POS : center;
        hi      = MAX_POS - c;
        lim     = (hi < c) ? hi : c;
        max_amp = {lim[AMP_W-5:0], 4'b0000};
        limited = amplitude > max_amp;
        amp     = limited ? max_amp : amplitude;
        go      = run && (amp != '0) && (phase_step != '0);

        addr = phase_acc_reg[PHASE_W-1 -: SINE_ADDR_W];
        r    = addr[QTR_W-1:0];
        u    = addr[QTR_W] ? ((QTR_W+1)'(SINE_QTR) - {1'b0, r}) : {1'b0, r};

        s1_next.center  = c;
        s1_next.amp     = amp;
        s1_next.mag     = SINE_ROM[u];
        s1_next.neg     = addr[SINE_ADDR_W-1];
        s1_next.limited = limited;
        s1_next.moving  = go;

        phase_acc_next = go ? (phase_acc_reg + phase_step) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            phase_acc_reg <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (accept)
            begin
                phase_acc_reg <= phase_acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    a_hold_clears_phase: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !go |=> phase_acc_reg == '0)
        else $error("phase not cleared on hold");

    a_phase_advance: assert property (@(posedge clk) disable iff (!rst_n)
        accept && go |=> phase_acc_reg == $past(phase_acc_reg + phase_step))
        else $error("phase did not advance by step");

    a_moving_amp: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_reg.moving |-> s1_reg.amp != '0)
        else $error("moving with zero amplitude");

endmodule

[src/sssg_mix.sv]
// ----------------------------------------------------------------------------
// sssg_mix
// Scale the sine magnitude by the amplitude, round, apply around the center
// with clamping, and hold the result transaction.
// ----------------------------------------------------------------------------
module sssg_mix (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s1_valid,
    input  sssg_pkg::stage_t           s1,
    output logic                       s1_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [sssg_pkg::POS_W-1:0] position,
    output logic                       amplitude_limited,
    output logic                       moving
);
    import sssg_pkg::*;

    logic                 out_valid_reg;
    logic [POS_W-1:0]     position_reg;
    logic [POS_W-1:0]     position_next;
    logic                 limited_reg;
    logic                 moving_reg;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W:0]      prod_rnd;
    logic [OFF_W-1:0]     off;
    logic [OFF_W:0]       up;
    logic                 take;

    assign s1_ready          = !out_valid_reg || out_ready;
    assign take              = s1_valid && s1_ready;
    assign out_valid         = out_valid_reg;
    assign position          = position_reg;
    assign amplitude_limited = limited_reg;
    assign moving            = moving_reg;

    always_comb
    begin
        prod     = PROD_W'(s1.amp) * PROD_W'(s1.mag);
        prod_rnd = {1'b0, prod} + ((PROD_W+1)'(1) << 19);
        off      = prod_rnd[20 +: OFF_W];
        up       = {2'b00, s1.center} + {1'b0, off};
        if (!s1.moving)
        begin
            position_next = s1.center;
        end
        else if (s1.neg)
        begin
            position_next = (off > {1'b0, s1.center}) ? '0
                          : POS_W'({1'b0, s1.center} - off);
        end
        else
        begin
            position_next = (up > (OFF_W+1)'(MAX_POS)) ? MAX_POS : up[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            out_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            position_reg <= position_next;
            limited_reg  <= s1.limited;
            moving_reg   <= s1.moving;
        end
    end

endmodule

[src/servo_sine_shake_generator_core.sv]
// ----------------------------------------------------------------------------
// servo_sine_shake_generator_core
// Sine oscillator around a servo center position, one position per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one tick and yields one output transaction after
// two register stages, the sine table lookup stage and the amplitude multiply
// stage; a new tick is accepted every cycle while the output is not stalled by
// m_axis_tready. The user writes registers through cfg_we/cfg_index/cfg_data
// only while no tick is in flight; the block itself does not enforce this.
module servo_sine_shake_generator_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [0] run
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata,   // [10:0] position,
                                                            // [11] amplitude_limited,
                                                            // [12] moving
    input  logic                            cfg_we,
    input  logic [sssg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sssg_pkg::CFG_DATA_W-1:0] cfg_data
);
    import sssg_pkg::*;

    logic [POS_W-1:0]   center_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic [PHASE_W-1:0] phase_step_reg;
    logic               s1_valid;
    stage_t             s1;
    logic               s1_ready;
    logic [POS_W-1:0]   position;
    logic               amplitude_limited;
    logic               moving;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg     <= CENTER_RESET;
            amplitude_reg  <= '0;
            phase_step_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CENTER:     center_reg     <= cfg_data[POS_W-1:0];
                CFG_AMPLITUDE:  amplitude_reg  <= cfg_data[AMP_W-1:0];
                CFG_PHASE_STEP: phase_step_reg <= cfg_data[PHASE_W-1:0];
                default:        ;
            endcase
        end
    end

    sssg_phase u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .run        (s_axis_tdata[0]),
        .center     (center_reg),
        .amplitude  (amplitude_reg),
        .phase_step (phase_step_reg),
        .s1_valid   (s1_valid),
        .s1         (s1),
        .s1_ready   (s1_ready)
    );

    sssg_mix u_mix (
        .clk               (clk),
        .rst_n             (rst_n),
        .s1_valid          (s1_valid),
        .s1                (s1),
        .s1_ready          (s1_ready),
        .out_valid         (m_axis_tvalid),
        .out_ready         (m_axis_tready),
        .position          (position),
        .amplitude_limited (amplitude_limited),
        .moving            (moving)
    );

    assign m_axis_tdata = {3'b000, moving, amplitude_limited, position};

endmodule

[tb/shake_position_checker.sv]
// ----------------------------------------------------------------------------
// shake_position_checker
// Watches the tick, position and register channels of the shake generator,
// works out each expected position from its own oscillator state and
// compares every output transaction against the oldest expected one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shake_position_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,   // [0] run
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [15:0]                     m_axis_tdata,   // [10:0] position,
                                                            // [11] amplitude_limited,
                                                            // [12] moving
    input  logic                            cfg_we,
    input  logic [sssg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sssg_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              pending,
    output int                              failures
);
    import sssg_pkg::*;

    typedef struct packed {
        logic [POS_W-1:0] position;
        logic             limited;
        logic             moving;
    } shake_out_t;

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] TAYLOR_Q30 [0:6] = '{
        64'd1686629713, 64'd693598668, 64'd85569306, 64'd5026995,
        64'd172272, 64'd3864, 64'd61
    };

    logic [POS_W-1:0]   center_reg;
    logic [AMP_W-1:0]   amplitude_reg;
    logic [PHASE_W-1:0] step_reg;
    logic [PHASE_W-1:0] phase;
    shake_out_t         expected_positions [$];
    int                 result_idx;

    function automatic logic [63:0] quarter_wave_q30(input logic [63:0] v);
        logic [63:0] v2;
        logic [63:0] t;
        logic [63:0] sub;
        int          k;
        v2 = (v * v) >> 30;
        t  = TAYLOR_Q30[6];
        for (k = 5; k >= 0; k--)
        begin
            sub = (v2 * t) >> 30;
            t   = (TAYLOR_Q30[k] > sub) ? (TAYLOR_Q30[k] - sub) : 64'd0;
        end
        t = (v * t) >> 30;
        return (t > ONE_Q30) ? ONE_Q30 : t;
    endfunction

    function automatic logic [63:0] sine_magnitude(input logic [SINE_ADDR_W-1:0] addr);
        logic [1:0]  quadrant;
        logic [63:0] r;
        logic [63:0] u;
        logic [63:0] m;
        quadrant = addr[SINE_ADDR_W-1 -: 2];
        r        = 64'(addr[QTR_W-1:0]);
        u        = quadrant[0] ? (64'(SINE_QTR) - r) : r;
        m        = (quarter_wave_q30(u << (30 - QTR_W)) + 64'd8192) >> 14;
        return (m > 64'd65536) ? 64'd65536 : m;
    endfunction

    function automatic shake_out_t next_position(input logic run_bit);
        shake_out_t  res;
        logic [63:0] c;
        logic [63:0] room;
        logic [63:0] amp;
        logic [63:0] off;
        logic [SINE_ADDR_W-1:0] addr;
        c    = 64'(center_reg);
        room = ((64'd2047 - c) < c) ? (64'd2047 - c) : c;
        amp  = 64'(amplitude_reg);
        res.limited = 1'b0;
        if (amp > (room << 4))
        begin
            amp         = room << 4;
            res.limited = 1'b1;
        end
        if (!run_bit || amp == 64'd0 || step_reg == '0)
        begin
            phase        = '0;
            res.position = POS_W'(c);
            res.moving   = 1'b0;
        end
        else
        begin
            addr = phase[PHASE_W-1 -: SINE_ADDR_W];
            off  = (amp * sine_magnitude(addr) + (64'd1 << 19)) >> 20;
            if (addr[SINE_ADDR_W-1])
                res.position = (off > c) ? '0 : POS_W'(c - off);
            else
                res.position = (c + off > 64'd2047) ? MAX_POS : POS_W'(c + off);
            phase      = phase + step_reg;
            res.moving = 1'b1;
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        shake_out_t exp_item;
        shake_out_t got;
        if (!rst_n)
        begin
            center_reg    = CENTER_RESET;
            amplitude_reg = '0;
            step_reg      = '0;
            phase         = '0;
            expected_positions.delete();
            result_idx    = 0;
            failures      = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER:     center_reg    = cfg_data[POS_W-1:0];
                    CFG_AMPLITUDE:  amplitude_reg = cfg_data[AMP_W-1:0];
                    CFG_PHASE_STEP: step_reg      = cfg_data[PHASE_W-1:0];
                    default:        ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = {m_axis_tdata[10:0], m_axis_tdata[11], m_axis_tdata[12]};
                if (expected_positions.size() == 0)
                begin
                    if (failures < 10)
                        $display("result %0d: unexpected transaction pos=%0d lim=%0d mov=%0d",
                                 result_idx, got.position, got.limited, got.moving);
                    failures++;
                end
                else
                begin
                    exp_item = expected_positions.pop_front();
                    if (got !== exp_item)
                    begin
                        if (failures < 10)
                            $display({"result %0d: expected pos=%0d lim=%0d mov=%0d, ",
                                      "got pos=%0d lim=%0d mov=%0d"}, result_idx,
                                     exp_item.position, exp_item.limited, exp_item.moving,
                                     got.position, got.limited, got.moving);
                        failures++;
                    end
                end
                result_idx++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_positions.push_back(next_position(s_axis_tdata[0]));
            pending <= expected_positions.size();
        end
    end

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and register writes into the shake generator under changing
// backpressure; a checker beside the block predicts and compares positions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import sssg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam int CYCLE_LIMIT = 400000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [7:0]            s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_CENTER;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int pending;
    int failures;
    int cycles = 0;
    int tx_idle_pct = 34;
    int rx_idle_pct = 83;

    servo_sine_shake_generator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    shake_position_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .failures      (failures)
    );

    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic send_tick(input logic run_bit);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 8'(run_bit);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // drop valid, then wait until every expected position has arrived
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_burst(input int count, input logic run_bit);
        repeat (count)
            send_tick(run_bit);
    endtask

    task automatic random_setting;
        case ($urandom_range(3))
            0:       write_reg(CFG_CENTER, $urandom_range(1) ? 32'd2047 : 32'd0);
            default: write_reg(CFG_CENTER, $urandom());
        endcase
        case ($urandom_range(3))
            0:       write_reg(CFG_AMPLITUDE, 32'd0);
            1:       write_reg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
            default: write_reg(CFG_AMPLITUDE, $urandom());
        endcase
        case ($urandom_range(7))
            0:       write_reg(CFG_PHASE_STEP, 32'd0);
            1:       write_reg(CFG_PHASE_STEP, $urandom_range(1 << 20, 1));
            2:       write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
            default: write_reg(CFG_PHASE_STEP, $urandom());
        endcase
        if ($urandom_range(5) == 0)
            write_reg(CFG_UNUSED, $urandom());
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero amplitude and zero step hold the center
        send_tick(1'b1);
        send_tick(1'b0);

        // centers at both ends leave no room, amplitude limited to zero
        write_reg(CFG_CENTER, 32'd0);
        write_reg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
        write_reg(CFG_PHASE_STEP, 32'h4000_0000);
        send_burst(2, 1'b1);
        write_reg(CFG_CENTER, 32'hFFFF_FFFF);
        send_tick(1'b1);

        // full swing in quarter-turn steps, stop and restart
        write_reg(CFG_CENTER, 32'd1024);
        write_reg(CFG_AMPLITUDE, 32'd16368);
        send_burst(5, 1'b1);
        send_tick(1'b0);
        send_burst(2, 1'b1);
        write_reg(CFG_AMPLITUDE, 32'd32767);
        send_burst(2, 1'b1);
        write_reg(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        send_burst(3, 1'b1);
        write_reg(CFG_PHASE_STEP, 32'd0);
        send_tick(1'b1);

        // unused register index is ignored
        write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
        write_reg(CFG_CENTER, 32'd1);
        write_reg(CFG_AMPLITUDE, 32'd100);
        write_reg(CFG_PHASE_STEP, 32'h0123_4567);
        send_burst(4, 1'b1);

        for (int regime = 0; regime < 3; regime++)
        begin
            drain();
            case (regime)
                0:
                begin
                    tx_idle_pct = 34;
                    rx_idle_pct = 83;
                end
                1:
                begin
                    tx_idle_pct = 83;
                    rx_idle_pct = 34;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            repeat (8)
            begin
                random_setting();
                repeat ($urandom_range(40, 20))
                    send_tick($urandom_range(15) != 0);
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (failures == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
